// ===== design/sstvyc_pkg.sv =====
// Shared types and constants of the SSTV luma and color-difference converter.
package sstvyc_pkg;

  localparam logic [14:0] LUMA_G        = 15'd59;
  localparam logic [14:0] LUMA_R        = 15'd30;
  localparam logic [14:0] LUMA_B        = 15'd11;
  localparam logic [29:0] LUMA_RECIP    = 30'd20972;
  localparam int          LUMA_SHIFT    = 21;

  localparam logic [12:0] RED_GAIN      = 13'd10;
  localparam logic [12:0] RED_OFFSET    = 13'd1785;
  localparam logic [12:0] RED_Y_GAIN    = 13'd5;
  localparam logic [12:0] RED_SAT       = 13'd3570;
  localparam logic [24:0] RED_RECIP     = 25'd4682;
  localparam int          RED_SHIFT     = 16;

  localparam logic [15:0] BLUE_GAIN     = 16'd100;
  localparam logic [15:0] BLUE_OFFSET   = 16'd22695;
  localparam logic [15:0] BLUE_Y_GAIN   = 16'd50;
  localparam logic [15:0] BLUE_SAT      = 16'd45390;
  localparam logic [31:0] BLUE_RECIP    = 32'd47128;
  localparam int          BLUE_SHIFT    = 23;

  localparam logic [7:0]  BYTE_MAX      = 8'd255;

  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] red_avg;
    logic [7:0] blue_avg;
    logic       paired;
  } luma_t;

endpackage

// ===== design/sstvyc_ifs.sv =====
// Handshake channel interfaces for pixel items, result items and configuration.
interface sstvyc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] even_red;
  logic [7:0] even_green;
  logic [7:0] even_blue;
  logic [7:0] odd_red;
  logic [7:0] odd_green;
  logic [7:0] odd_blue;
  modport source(output valid, even_red, even_green, even_blue, odd_red, odd_green,
                 odd_blue, input ready);
  modport sink(input valid, even_red, even_green, even_blue, odd_red, odd_green,
               odd_blue, output ready);
endinterface

interface sstvyc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_even;
  logic [7:0] luma_odd;
  logic [7:0] red_diff;
  logic [7:0] blue_diff;
  modport source(output valid, luma_even, luma_odd, red_diff, blue_diff, input ready);
  modport sink(input valid, luma_even, luma_odd, red_diff, blue_diff, output ready);
endinterface

interface sstvyc_cfg_if;
  logic valid;
  logic ready;
  logic paired_mode;
  modport source(output valid, paired_mode, input ready);
  modport sink(input valid, paired_mode, output ready);
endinterface

// ===== design/sstvyc_luma.sv =====
// Luma stages: weighted RGB sums, then reciprocal divide by 100, plus red and blue row averages in paired mode.
module sstvyc_luma
  import sstvyc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       paired_mode,
  sstvyc_in_if.sink  in_ch,
  output logic       lm_valid,
  input  logic       lm_ready,
  output luma_t      lm_data
);

  logic        v1_r;
  logic        v2_r;
  logic        ready1;
  logic        ready2;
  logic [14:0] lnum_e_r;
  logic [14:0] lnum_o_r;
  logic [7:0]  ravg_r;
  logic [7:0]  bavg_r;
  logic        paired_r;
  logic [14:0] lnum_e_nxt;
  logic [14:0] lnum_o_nxt;
  logic [7:0]  ravg_nxt;
  logic [7:0]  bavg_nxt;
  logic [29:0] prod_e;
  logic [29:0] prod_o;
  luma_t       data_r;
  luma_t       data_nxt;

  assign ready2      = !v2_r || lm_ready;
  assign ready1      = !v1_r || ready2;
  assign in_ch.ready = ready1;

  always_comb begin
    lnum_e_nxt = 15'(in_ch.even_green) * LUMA_G + 15'(in_ch.even_red) * LUMA_R
               + 15'(in_ch.even_blue) * LUMA_B;
    if (paired_mode) begin
      lnum_o_nxt = 15'(in_ch.odd_green) * LUMA_G + 15'(in_ch.odd_red) * LUMA_R
                 + 15'(in_ch.odd_blue) * LUMA_B;
      ravg_nxt   = 8'((9'(in_ch.even_red) + 9'(in_ch.odd_red)) >> 1);
      bavg_nxt   = 8'((9'(in_ch.even_blue) + 9'(in_ch.odd_blue)) >> 1);
    end else begin
      lnum_o_nxt = '0;
      ravg_nxt   = in_ch.even_red;
      bavg_nxt   = in_ch.even_blue;
    end
  end

  always_comb begin
    prod_e             = 30'(lnum_e_r) * LUMA_RECIP;
    prod_o             = 30'(lnum_o_r) * LUMA_RECIP;
    data_nxt.luma_even = prod_e[LUMA_SHIFT +: 8];
    data_nxt.luma_odd  = prod_o[LUMA_SHIFT +: 8];
    data_nxt.red_avg   = ravg_r;
    data_nxt.blue_avg  = bavg_r;
    data_nxt.paired    = paired_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_ch.valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && ready1) begin
      lnum_e_r <= lnum_e_nxt;
      lnum_o_r <= lnum_o_nxt;
      ravg_r   <= ravg_nxt;
      bavg_r   <= bavg_nxt;
      paired_r <= paired_mode;
    end
    if (v1_r && ready2) begin
      data_r <= data_nxt;
    end
  end

  assign lm_valid = v2_r;
  assign lm_data  = data_r;

endmodule

// ===== design/sstvyc_chroma.sv =====
// Chroma stages: offset differences with saturation, then reciprocal divides.
module sstvyc_chroma
  import sstvyc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        lm_valid,
  output logic        lm_ready,
  input  luma_t       lm_data,
  sstvyc_out_if.source out_ch
);

  logic        v1_r;
  logic        v2_r;
  logic        ready1;
  logic        ready2;
  logic [8:0]  ysum;
  logic [12:0] rpos;
  logic [12:0] rsub;
  logic [12:0] rdiff;
  logic [15:0] bpos;
  logic [15:0] bsub;
  logic [15:0] bdiff;
  logic [7:0]  ye_r;
  logic [7:0]  yo_r;
  logic [11:0] rn_r;
  logic [15:0] bn_r;
  logic        rneg_r;
  logic        rhi_r;
  logic        bneg_r;
  logic        bhi_r;
  logic [24:0] rprod;
  logic [31:0] bprod;
  logic [7:0]  rd_nxt;
  logic [7:0]  bd_nxt;
  logic [7:0]  luma_even_r;
  logic [7:0]  luma_odd_r;
  logic [7:0]  red_diff_r;
  logic [7:0]  blue_diff_r;

  assign ready2   = !v2_r || out_ch.ready;
  assign ready1   = !v1_r || ready2;
  assign lm_ready = ready1;

  always_comb begin
    if (lm_data.paired) begin
      ysum = 9'(lm_data.luma_even) + 9'(lm_data.luma_odd);
    end else begin
      ysum = {lm_data.luma_even, 1'b0};
    end
    rpos  = 13'(lm_data.red_avg) * RED_GAIN + RED_OFFSET;
    rsub  = 13'(ysum) * RED_Y_GAIN;
    rdiff = rpos - rsub;
    bpos  = 16'(lm_data.blue_avg) * BLUE_GAIN + BLUE_OFFSET;
    bsub  = 16'(ysum) * BLUE_Y_GAIN;
    bdiff = bpos - bsub;
  end

  always_comb begin
    rprod = 25'(rn_r) * RED_RECIP;
    bprod = 32'(bn_r) * BLUE_RECIP;
    if (rneg_r) begin
      rd_nxt = '0;
    end else if (rhi_r) begin
      rd_nxt = BYTE_MAX;
    end else begin
      rd_nxt = rprod[RED_SHIFT +: 8];
    end
    if (bneg_r) begin
      bd_nxt = '0;
    end else if (bhi_r) begin
      bd_nxt = BYTE_MAX;
    end else begin
      bd_nxt = bprod[BLUE_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= lm_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lm_valid && ready1) begin
      ye_r   <= lm_data.luma_even;
      yo_r   <= lm_data.luma_odd;
      rneg_r <= rpos < rsub;
      rhi_r  <= rdiff >= RED_SAT;
      rn_r   <= rdiff[11:0];
      bneg_r <= bpos < bsub;
      bhi_r  <= bdiff >= BLUE_SAT;
      bn_r   <= bdiff;
    end
    if (v1_r && ready2) begin
      luma_even_r <= ye_r;
      luma_odd_r  <= yo_r;
      red_diff_r  <= rd_nxt;
      blue_diff_r <= bd_nxt;
    end
  end

  assign out_ch.valid     = v2_r;
  assign out_ch.luma_even = luma_even_r;
  assign out_ch.luma_odd  = luma_odd_r;
  assign out_ch.red_diff  = red_diff_r;
  assign out_ch.blue_diff = blue_diff_r;

endmodule

// ===== design/sstv_rgb_to_luma_chroma_pair_top.sv =====
// Top level of the SSTV RGB to luma and color-difference converter.
// Takes one pixel column (even-row and odd-row RGB) per cycle while the output is not
// stalled and returns luma for both rows (odd-row luma is 0 in single-row mode) plus
// red and blue color differences, all clamped to 0..255. The block is a four-stage
// pipeline; each stage holds its own valid bit, so bubbles close up while the output
// is stalled. The paired_mode register (reset 0, single row) is written through the
// cfg channel, which is always ready.
module sstv_rgb_to_luma_chroma_pair_top
  import sstvyc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sstvyc_cfg_if.sink   cfg_ch,
  sstvyc_in_if.sink    in_ch,
  sstvyc_out_if.source out_ch
);

  logic  paired_mode_r;
  logic  lm_valid;
  logic  lm_ready;
  luma_t lm_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paired_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      paired_mode_r <= cfg_ch.paired_mode;
    end
  end

  sstvyc_luma u_luma (
    .clk         (clk),
    .rst_n       (rst_n),
    .paired_mode (paired_mode_r),
    .in_ch       (in_ch),
    .lm_valid    (lm_valid),
    .lm_ready    (lm_ready),
    .lm_data     (lm_data)
  );

  sstvyc_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .lm_valid (lm_valid),
    .lm_ready (lm_ready),
    .lm_data  (lm_data),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/sv/sstv_rgb_to_luma_chroma_pair_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the SSTV luma and color-difference pair converter.
module sstv_rgb_to_luma_chroma_pair_top_tb;

  typedef struct packed {
    logic [7:0] even_red;
    logic [7:0] even_green;
    logic [7:0] even_blue;
    logic [7:0] odd_red;
    logic [7:0] odd_green;
    logic [7:0] odd_blue;
  } rgb_pair_t;

  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] luma_odd;
    logic [7:0] red_diff;
    logic [7:0] blue_diff;
  } luma_chroma_t;

  localparam int GREEN_WEIGHT    = 59;
  localparam int RED_WEIGHT      = 30;
  localparam int BLUE_WEIGHT     = 11;
  localparam int LUMA_DIVISOR    = 100;
  localparam int RED_BIAS        = 7 * 255;
  localparam int RED_DIVISOR     = 14;
  localparam int BLUE_BIAS       = 89 * 255;
  localparam int BLUE_DIVISOR    = 178;
  localparam int BYTE_TOP        = 255;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int OUT_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 100;

  logic clk;
  logic rst_n;

  sstvyc_cfg_if cfg_if();
  sstvyc_in_if  in_if();
  sstvyc_out_if out_if();

  sstv_rgb_to_luma_chroma_pair_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  luma_chroma_t pending_results[$];
  luma_chroma_t oldest_result;
  bit           pairing;
  bit           sender_idle_on;
  bit           receiver_idle_on;
  bit           hold_request;
  int           mismatch_count;
  int           cycle_count;

  function automatic int luma_of_pixel(int r, int g, int b);
    return (GREEN_WEIGHT * g + RED_WEIGHT * r + BLUE_WEIGHT * b) / LUMA_DIVISOR;
  endfunction

  function automatic logic [7:0] clamp_to_byte(int v);
    if (v < 0) return 8'd0;
    if (v > BYTE_TOP) return 8'd255;
    return v[7:0];
  endfunction

  function automatic luma_chroma_t predict_luma_chroma(rgb_pair_t px, bit paired);
    int y_even;
    int y_odd;
    int red_mean;
    int blue_mean;
    int red_num;
    int blue_num;
    luma_chroma_t res;
    y_even = luma_of_pixel(px.even_red, px.even_green, px.even_blue);
    y_odd = 0;
    if (paired) begin
      y_odd = luma_of_pixel(px.odd_red, px.odd_green, px.odd_blue);
      red_mean = (int'(px.even_red) + int'(px.odd_red)) / 2;
      blue_mean = (int'(px.even_blue) + int'(px.odd_blue)) / 2;
      red_num = (10 * red_mean - 5 * (y_even + y_odd) + RED_BIAS) / RED_DIVISOR;
      blue_num = (100 * blue_mean - 50 * (y_even + y_odd) + BLUE_BIAS) / BLUE_DIVISOR;
    end else begin
      red_num = (10 * int'(px.even_red) - 10 * y_even + RED_BIAS) / RED_DIVISOR;
      blue_num = (100 * int'(px.even_blue) - 100 * y_even + BLUE_BIAS) / BLUE_DIVISOR;
    end
    res.luma_even = clamp_to_byte(y_even);
    res.luma_odd  = clamp_to_byte(y_odd);
    res.red_diff  = clamp_to_byte(red_num);
    res.blue_diff = clamp_to_byte(blue_num);
    return res;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_pair_t rand_pixel();
    rgb_pair_t px;
    px.even_red   = rand_byte();
    px.even_green = rand_byte();
    px.even_blue  = rand_byte();
    px.odd_red    = rand_byte();
    px.odd_green  = rand_byte();
    px.odd_blue   = rand_byte();
    return px;
  endfunction

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send_pixel(rgb_pair_t px);
    in_if.valid      <= 1'b1;
    in_if.even_red   <= px.even_red;
    in_if.even_green <= px.even_green;
    in_if.even_blue  <= px.even_blue;
    in_if.odd_red    <= px.odd_red;
    in_if.odd_green  <= px.odd_green;
    in_if.odd_blue   <= px.odd_blue;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_luma_chroma(px, pairing));
  endtask

  task automatic offer_pixel(rgb_pair_t px);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
    end
    send_pixel(px);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pairing(bit mode);
    drain_results();
    cfg_if.valid       <= 1'b1;
    cfg_if.paired_mode <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    pairing = mode;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_single_directed();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    offer_pixel(rgb_pair_t'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
    offer_pixel(rgb_pair_t'{8'd17, 8'd200, 8'd3, 8'd91, 8'd12, 8'd240});
    write_pairing(1'b0);
    offer_pixel(rgb_pair_t'{8'd128, 8'd128, 8'd128, 8'd1, 8'd2, 8'd3});
  endtask

  task automatic test_paired_directed();
    write_pairing(1'b1);
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    offer_pixel(rgb_pair_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
    offer_pixel(rgb_pair_t'{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
    offer_pixel(rgb_pair_t'{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
    offer_pixel(rgb_pair_t'{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255});
    offer_pixel(rgb_pair_t'{8'd1, 8'd0, 8'd2, 8'd2, 8'd0, 8'd1});
    offer_pixel(rgb_pair_t'{8'd255, 8'd0, 8'd255, 8'd254, 8'd0, 8'd254});
    offer_pixel(rgb_pair_t'{8'd90, 8'd33, 8'd180, 8'd7, 8'd222, 8'd65});
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      write_pairing(phase[0] ? 1'b0 : 1'b1);
      sender_idle_on = (phase != 2);
      receiver_idle_on = (phase != 2);
      repeat (PHASE_ITEMS) offer_pixel(rand_pixel());
    end
  endtask

  task automatic test_output_hold();
    write_pairing(1'b1);
    sender_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_pixel(rand_pixel());
    drain_results();
  endtask

  task automatic test_pause_refill();
    write_pairing(1'b0);
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (10) offer_pixel(rand_pixel());
    drain_results();
    repeat (10) offer_pixel(rand_pixel());
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sstv_rgb_to_luma_chroma_pair_top_tb NOT OK");
    $finish;
  end

  initial begin : receiver
    int run_left;
    run_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (OUT_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!receiver_idle_on || run_left > 0) begin
        out_if.ready <= 1'b1;
        if (run_left > 0) run_left--;
      end else begin
        out_if.ready <= 1'b0;
        repeat (gap_cycles() - 1) @(posedge clk);
        run_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                 out_if.luma_even, out_if.luma_odd, out_if.red_diff, out_if.blue_diff);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("luma_even", oldest_result.luma_even, out_if.luma_even);
        check_field("luma_odd", oldest_result.luma_odd, out_if.luma_odd);
        check_field("red_diff", oldest_result.red_diff, out_if.red_diff);
        check_field("blue_diff", oldest_result.blue_diff, out_if.blue_diff);
      end
    end
  end

  initial begin
    mismatch_count = 0;
    pairing = 1'b0;
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    hold_request = 1'b0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.even_red     <= 8'd0;
    in_if.even_green   <= 8'd0;
    in_if.even_blue    <= 8'd0;
    in_if.odd_red      <= 8'd0;
    in_if.odd_green    <= 8'd0;
    in_if.odd_blue     <= 8'd0;
    cfg_if.valid       <= 1'b0;
    cfg_if.paired_mode <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_directed();
    test_paired_directed();
    test_random_phases();
    test_output_hold();
    test_pause_refill();
    drain_results();
    if (mismatch_count == 0) begin
      $display("sstv_rgb_to_luma_chroma_pair_top_tb OK");
    end else begin
      $display("sstv_rgb_to_luma_chroma_pair_top_tb NOT OK");
    end
    $finish;
  end

endmodule
